// ----- design/ctc_pkg.sv -----
// ----------------------------------------------------------------------------
// ctc_pkg
// Shared types and constants of the color to class palette indexer.
// ----------------------------------------------------------------------------
package ctc_pkg;

  localparam int unsigned MAX_CLASSES = 254;
  localparam int unsigned CODE_W      = 8;
  localparam int unsigned ADDR_W      = $clog2(MAX_CLASSES);
  localparam int unsigned RGB_W       = 24;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [RGB_W-1:0]  rgb_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

// ----- design/ctc_if.sv -----
// ----------------------------------------------------------------------------
// ctc_pix_if / ctc_cls_if
// Valid/ready channels for pixel items and class result items.
// ----------------------------------------------------------------------------
interface ctc_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       first_pixel;
  modport source (output valid, red, green, blue, alpha, first_pixel, input ready);
  modport sink   (input valid, red, green, blue, alpha, first_pixel, output ready);
endinterface

interface ctc_cls_if;
  logic       valid;
  logic       ready;
  logic [7:0] class_code;
  logic       new_class;
  logic       color_dropped;
  modport source (output valid, class_code, new_class, color_dropped, input ready);
  modport sink   (input valid, class_code, new_class, color_dropped, output ready);
endinterface

// ----- design/color_to_class_palette_indexer_top.sv -----
// ----------------------------------------------------------------------------
// color_to_class_palette_indexer_top
// First-seen palette indexing of RGBA pixels into class codes.
// ----------------------------------------------------------------------------
// flow: pixels with alpha zero or an empty table skip the scan; a new pixel is
//   taken only in the idle state, once the previous result is in the output
//   register; the single read port scans the color table one entry per cycle
// reset: class count cleared, table contents left undefined, no clearing pass
module color_to_class_palette_indexer_top (
  input  logic       clk,
  input  logic       rst,
  ctc_pix_if.sink    pix,
  ctc_cls_if.source  cls
);
  import ctc_pkg::*;

  state_t state, state_next;
  rgb_t   color_mem [MAX_CLASSES];
  rgb_t   rd_data;
  addr_t  rd_addr;
  logic   wr_en;
  addr_t  wr_addr;
  rgb_t   wr_data;

  code_t  count, count_next;
  code_t  idx, idx_next;
  rgb_t   rgb, rgb_next;
  code_t  pend_code, pend_code_next;
  logic   pend_new, pend_new_next;
  logic   pend_drop, pend_drop_next;

  logic   accept;
  code_t  count_eff;
  code_t  idx_inc;
  logic   table_full;

  assign accept     = pix.valid && pix.ready;
  assign pix.ready  = (state == S_IDLE);
  assign count_eff  = pix.first_pixel ? '0 : count;
  assign idx_inc    = idx + code_t'(1);
  assign table_full = (count >= code_t'(MAX_CLASSES));

  // color table memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      color_mem[wr_addr] <= wr_data;
    end
    rd_data <= color_mem[rd_addr];
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cls.valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == S_DONE && (!cls.valid || cls.ready)) begin
        cls.valid <= 1'b1;
      end else if (cls.ready) begin
        cls.valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx       <= idx_next;
    rgb       <= rgb_next;
    pend_code <= pend_code_next;
    pend_new  <= pend_new_next;
    pend_drop <= pend_drop_next;
    if (state == S_DONE && (!cls.valid || cls.ready)) begin
      cls.class_code    <= pend_code;
      cls.new_class     <= pend_new;
      cls.color_dropped <= pend_drop;
    end
  end

  // next state, memory access and result
  always_comb begin
    state_next     = state;
    count_next     = count;
    idx_next       = idx;
    rgb_next       = rgb;
    pend_code_next = pend_code;
    pend_new_next  = pend_new;
    pend_drop_next = pend_drop;
    wr_en          = 1'b0;
    wr_addr        = count[ADDR_W-1:0];
    wr_data        = rgb;
    rd_addr        = idx_inc[ADDR_W-1:0];
    case (state)
      S_IDLE: begin
        rd_addr = '0;
        if (accept) begin
          rgb_next       = {pix.red, pix.green, pix.blue};
          count_next     = count_eff;
          idx_next       = '0;
          pend_code_next = '0;
          pend_new_next  = 1'b0;
          pend_drop_next = 1'b0;
          if (pix.alpha == '0) begin
            state_next = S_DONE;
          end else if (count_eff == '0) begin
            // empty table: first color takes class 1
            wr_en          = 1'b1;
            wr_addr        = '0;
            wr_data        = {pix.red, pix.green, pix.blue};
            count_next     = code_t'(1);
            pend_code_next = code_t'(1);
            pend_new_next  = 1'b1;
            state_next     = S_DONE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (rd_data == rgb) begin
          pend_code_next = idx_inc;
          state_next     = S_DONE;
        end else if (idx_inc == count) begin
          // miss: insert or drop
          if (table_full) begin
            pend_drop_next = 1'b1;
          end else begin
            wr_en          = 1'b1;
            count_next     = count + code_t'(1);
            pend_code_next = count + code_t'(1);
            pend_new_next  = 1'b1;
          end
          state_next = S_DONE;
        end else begin
          idx_next = idx_inc;
        end
      end
      S_DONE: begin
        if (!cls.valid || cls.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/ctc_checker.sv -----
// ----------------------------------------------------------------------------
// ctc_checker
// Port-level checks on result items of the palette indexer.
// ----------------------------------------------------------------------------
module ctc_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] class_code,
  input logic       new_class,
  input logic       color_dropped
);
  import ctc_pkg::*;

  // class code never exceeds the class limit
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (class_code <= 8'(MAX_CLASSES)))
    else $error("class code out of range");

  // a dropped color is never also new
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(new_class && color_dropped))
    else $error("new and dropped together");

  // dropped item carries class zero
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && color_dropped) |-> (class_code == 8'd0))
    else $error("dropped item with nonzero class");

  // new class carries a real code
  a_new_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && new_class) |-> (class_code != 8'd0))
    else $error("new class with code zero");

  // stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(class_code)))
    else $error("stalled item changed");

endmodule

bind color_to_class_palette_indexer_top ctc_checker u_ctc_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (cls.valid),
  .out_ready     (cls.ready),
  .class_code    (cls.class_code),
  .new_class     (cls.new_class),
  .color_dropped (cls.color_dropped)
);

// ----- test/tb_color_to_class_palette_indexer_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_color_to_class_palette_indexer_top
// Sends RGBA pixel items through the palette indexer and checks each class
// item against a local palette model, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_color_to_class_palette_indexer_top;
  import ctc_pkg::*;

  typedef struct packed {
    code_t code;
    logic  fresh;
    logic  dropped;
  } cls_exp_t;

  logic clk;
  logic rst;
  bit   failed;
  bit   no_idle;
  int   got_cnt;
  int   sent_cnt;

  rgb_t     palette[MAX_CLASSES];
  int       palette_cnt;
  cls_exp_t cls_queue[$];

  ctc_pix_if pix ();
  ctc_cls_if cls ();

  color_to_class_palette_indexer_top u_top (
    .clk (clk),
    .rst (rst),
    .pix (pix.sink),
    .cls (cls.source)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #50ms;
    $display("end of test: mismatches");
    $finish;
  end

  // palette model: expected class item for one pixel
  function automatic cls_exp_t classify_pixel(logic [7:0] r, logic [7:0] g,
                                              logic [7:0] b, logic [7:0] a,
                                              logic first);
    cls_exp_t res;
    rgb_t     rgb;
    res = '0;
    rgb = {r, g, b};
    if (first) palette_cnt = 0;
    if (a != 8'd0) begin
      for (int k = 0; k < palette_cnt; k++) begin
        if (palette[k] == rgb && res.code == 0) res.code = code_t'(k + 1);
      end
      if (res.code == 0) begin
        if (palette_cnt >= MAX_CLASSES) begin
          res.dropped = 1'b1;
        end else begin
          palette[palette_cnt] = rgb;
          palette_cnt++;
          res.code  = code_t'(palette_cnt);
          res.fresh = 1'b1;
        end
      end
    end
    return res;
  endfunction

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(99) < 29);
  endfunction

  // send one pixel item; valid stays high into the next call unless it idles
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            logic [7:0] a, logic first);
    while (idle_now()) begin
      pix.valid <= 1'b0;
      @(negedge clk);
    end
    pix.valid       <= 1'b1;
    pix.red         <= r;
    pix.green       <= g;
    pix.blue        <= b;
    pix.alpha       <= a;
    pix.first_pixel <= first;
    do @(posedge clk); while (!pix.ready);
    cls_queue.push_back(classify_pixel(r, g, b, a, first));
    sent_cnt++;
    @(negedge clk);
  endtask

  // result sink with random stall
  always @(negedge clk) begin
    if (rst) cls.ready <= 1'b0;
    else cls.ready <= !idle_now();
  end

  // result check
  always @(posedge clk) begin
    cls_exp_t want;
    if (!rst && cls.valid && cls.ready) begin
      got_cnt++;
      if (cls_queue.size() == 0) begin
        $display("%0t: unexpected class item code=%0d", $time, cls.class_code);
        failed = 1'b1;
      end else begin
        want = cls_queue.pop_front();
        if (cls.class_code !== want.code) begin
          $display("%0t: class_code expected %0d actual %0d", $time, want.code,
                   cls.class_code);
          failed = 1'b1;
        end
        if (cls.new_class !== want.fresh) begin
          $display("%0t: new_class expected %0b actual %0b", $time, want.fresh,
                   cls.new_class);
          failed = 1'b1;
        end
        if (cls.color_dropped !== want.dropped) begin
          $display("%0t: color_dropped expected %0b actual %0b", $time,
                   want.dropped, cls.color_dropped);
          failed = 1'b1;
        end
      end
    end
  end

  // extremes, no-data, black, repeats, image restart
  task automatic test_directed();
    send_pixel(8'h00, 8'h00, 8'h00, 8'hff, 1'b1);
    send_pixel(8'hff, 8'hff, 8'hff, 8'h01, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 8'h80, 1'b0);
    send_pixel(8'hff, 8'hff, 8'hff, 8'h00, 1'b0);
    send_pixel(8'h12, 8'h34, 8'h56, 8'h00, 1'b0);
    send_pixel(8'haa, 8'h55, 8'haa, 8'h7f, 1'b0);
    send_pixel(8'h55, 8'haa, 8'h55, 8'hfe, 1'b0);
    send_pixel(8'hff, 8'hff, 8'hff, 8'hff, 1'b0);
    send_pixel(8'haa, 8'h55, 8'haa, 8'h01, 1'b0);
    send_pixel(8'h01, 8'h02, 8'h03, 8'h00, 1'b1);
    send_pixel(8'haa, 8'h55, 8'haa, 8'hff, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 8'hff, 1'b1);
    send_pixel(8'h00, 8'h00, 8'h00, 8'hff, 1'b0);
  endtask

  // fill the table to the limit, then hit the full case and the last entry
  task automatic test_table_full();
    send_pixel(8'd0, 8'd0, 8'd0, 8'hff, 1'b1);
    for (int k = 1; k < MAX_CLASSES; k++) send_pixel(8'(k), 8'h80, 8'(~k), 8'h40, 1'b0);
    send_pixel(8'hfe, 8'hfe, 8'hfe, 8'hff, 1'b0);
    send_pixel(8'hff, 8'hff, 8'hff, 8'h01, 1'b0);
    send_pixel(8'(MAX_CLASSES - 1), 8'h80, 8'(~(MAX_CLASSES - 1)), 8'hff, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 8'h00, 1'b0);
    for (int k = 0; k < 20; k++)
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(255, 1)), 1'b0);
  endtask

  // random images from a small palette, with noise colors and no-data pixels
  task automatic test_random_images();
    rgb_t       pal[16];
    int         img_len;
    int         pal_n;
    int         pick;
    logic [7:0] a;
    rgb_t       c;
    while (sent_cnt < 1000) begin
      no_idle = ($urandom_range(9) == 0);
      pal_n   = $urandom_range(16, 1);
      for (int k = 0; k < 16; k++) pal[k] = rgb_t'($urandom);
      img_len = $urandom_range(60, 5);
      for (int i = 0; i < img_len; i++) begin
        pick = $urandom_range(99);
        c    = (pick < 85) ? pal[$urandom_range(pal_n - 1)] : rgb_t'($urandom);
        a    = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(255, 1));
        send_pixel(c[23:16], c[15:8], c[7:0], a, i == 0);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst             = 1'b1;
    failed          = 1'b0;
    no_idle         = 1'b0;
    got_cnt         = 0;
    sent_cnt        = 0;
    palette_cnt     = 0;
    pix.valid       = 1'b0;
    pix.red         = '0;
    pix.green       = '0;
    pix.blue        = '0;
    pix.alpha       = '0;
    pix.first_pixel = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_table_full();
    test_random_images();
    pix.valid <= 1'b0;
    while (cls_queue.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (!failed && cls_queue.size() == 0 && got_cnt == sent_cnt) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
